>>> hw/rtl/ccfg_pkg.sv
// shared types, constants and microcode table of the coulomb counter fuel gauge
package ccfg_pkg;

    // arithmetic constants
    localparam logic [31:0] MS_PER_HOUR  = 32'd3600000;
    localparam logic [14:0] PCT_Q8_FULL  = 15'd25600;
    localparam logic [15:0] CAP_RESET    = 16'd1000;

    // divider iteration counts, two quotient bits per iteration
    localparam int          DIV_ITER_W    = 5;
    localparam logic [DIV_ITER_W-1:0] STEP_DIV_ITERS = 5'd22;
    localparam logic [DIV_ITER_W-1:0] PCT_DIV_ITERS  = 5'd8;

    // divider control from the sequencer
    typedef struct packed {
        logic                  start;
        logic [DIV_ITER_W-1:0] iters;
    } t_div_ctl;

    // micro operations, one per step
    typedef enum logic [3:0] {
        UOP_FETCH,
        UOP_MUL,
        UOP_DIV_STEP,
        UOP_WAIT,
        UOP_APPLY,
        UOP_PCT_MUL,
        UOP_DIV_PCT,
        UOP_OUT,
        UOP_LOAD
    } t_uop;

    // sequencing conditions
    typedef enum logic [2:0] {
        UC_NEXT,
        UC_GOTO,
        UC_IN_WAIT,
        UC_DIV_BUSY,
        UC_OUT_WAIT
    } t_ucond;

    typedef logic [3:0] t_upc;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    // step addresses
    localparam t_upc PC_FETCH    = 4'd0;
    localparam t_upc PC_MUL      = 4'd1;
    localparam t_upc PC_DIV_STEP = 4'd2;
    localparam t_upc PC_WAIT_STP = 4'd3;
    localparam t_upc PC_APPLY    = 4'd4;
    localparam t_upc PC_PCT_MUL  = 4'd5;
    localparam t_upc PC_DIV_PCT  = 4'd6;
    localparam t_upc PC_WAIT_PCT = 4'd7;
    localparam t_upc PC_OUT      = 4'd8;
    localparam t_upc PC_LOAD     = 4'd9;

    // microcode rom
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        begin
            case (pc)
                PC_FETCH:    w = '{op: UOP_FETCH,    cond: UC_IN_WAIT,  target: PC_LOAD};
                PC_MUL:      w = '{op: UOP_MUL,      cond: UC_NEXT,     target: PC_FETCH};
                PC_DIV_STEP: w = '{op: UOP_DIV_STEP, cond: UC_NEXT,     target: PC_FETCH};
                PC_WAIT_STP: w = '{op: UOP_WAIT,     cond: UC_DIV_BUSY, target: PC_FETCH};
                PC_APPLY:    w = '{op: UOP_APPLY,    cond: UC_NEXT,     target: PC_FETCH};
                PC_PCT_MUL:  w = '{op: UOP_PCT_MUL,  cond: UC_NEXT,     target: PC_FETCH};
                PC_DIV_PCT:  w = '{op: UOP_DIV_PCT,  cond: UC_NEXT,     target: PC_FETCH};
                PC_WAIT_PCT: w = '{op: UOP_WAIT,     cond: UC_DIV_BUSY, target: PC_FETCH};
                PC_OUT:      w = '{op: UOP_OUT,      cond: UC_OUT_WAIT, target: PC_FETCH};
                PC_LOAD:     w = '{op: UOP_LOAD,     cond: UC_GOTO,     target: PC_PCT_MUL};
                default:     w = '{op: UOP_WAIT,     cond: UC_GOTO,     target: PC_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

>>> hw/rtl/ccfg_div.sv
// radix-4 restoring divider, two quotient bits per clock
module ccfg_div
    import ccfg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctl              i_ctl,
    input  logic [31:0]           i_rem,
    input  logic [63:0]           i_qd,
    input  logic [31:0]           i_divisor,
    output logic                  o_busy,
    output logic [63:0]           o_quot
);

    logic                  r_busy;
    logic [DIV_ITER_W-1:0] r_cnt;
    logic [31:0]           r_rem;
    logic [63:0]           r_qd;
    logic [31:0]           r_div;

    logic [32:0] w_t1, w_d1, w_t2, w_d2;
    logic        w_ge1, w_ge2;
    logic [31:0] w_r1, w_r2;
    logic [63:0] n_qd;

    // two restoring subtract steps
    always_comb begin
        w_t1  = {r_rem, r_qd[63]};
        w_d1  = w_t1 - {1'b0, r_div};
        w_ge1 = (w_t1 >= {1'b0, r_div});
        w_r1  = w_ge1 ? w_d1[31:0] : w_t1[31:0];
        w_t2  = {w_r1, r_qd[62]};
        w_d2  = w_t2 - {1'b0, r_div};
        w_ge2 = (w_t2 >= {1'b0, r_div});
        w_r2  = w_ge2 ? w_d2[31:0] : w_t2[31:0];
        n_qd  = {r_qd[61:0], w_ge1, w_ge2};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_ctl.iters;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem;
            r_qd  <= i_qd;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_r2;
            r_qd  <= n_qd;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_qd;

endmodule

>>> hw/rtl/coulomb_counter_fuel_gauge.sv
// coulomb counter fuel gauge top level: microcoded sequencer and datapath
//
// Trapezoidal coulomb counter. Each current sample word integrates
// (I + Iprev) / 2 * dt into the used capacity (mAh, Q16.16), subtracting while
// charging and adding otherwise, clamped to 0..capacity; a load word presets
// the used capacity. Every word returns one result word with used capacity,
// remaining percent (Q8.8) and the charge moved by the sample. A small
// microcode program drives one 17x32 multiplier, one 32x15 multiplier and a
// shared radix-4 divider, which runs 22 iterations for the division by
// 3600000 and 8 for the percent. One word is in flight at a time; a new
// word is accepted while the previous result still waits in the output
// register, which holds one result until it is taken. The capacity
// register is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
module coulomb_counter_fuel_gauge
    import ccfg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [15:0] i_current_ma,
    input  logic [31:0]        i_time_ms,
    input  logic               i_charging,
    input  logic [31:0]        i_load_value,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_used_q16,
    output logic [14:0]        o_remaining_pct_q8,
    output logic signed [42:0] o_step_charge_q16,
    // capacity register
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);

    // sequencer state
    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w_uw;

    // architectural state
    logic [15:0]        r_cap;
    logic [31:0]        r_used;
    logic signed [15:0] r_last_cur;
    logic [31:0]        r_last_time;

    // captured input word
    logic signed [15:0] r_cur;
    logic [31:0]        r_time;
    logic               r_chg;
    logic [31:0]        r_load;

    // datapath registers
    logic               r_neg;
    logic [63:0]        r_acc;
    logic signed [42:0] r_step;
    logic               r_pct_zero;

    // output register
    logic               r_out_valid;
    logic [31:0]        r_o_used;
    logic [14:0]        r_o_pct;
    logic signed [42:0] r_o_step;

    // divider interface
    t_div_ctl    w_div_ctl;
    logic [31:0] w_div_rem;
    logic [63:0] w_div_qd;
    logic [31:0] w_div_divisor;
    logic        w_div_busy;
    logic [63:0] w_div_quot;

    // datapath wires
    logic               w_in_accept;
    logic               w_out_fire;
    logic [31:0]        w_cap_q16;
    logic signed [16:0] w_sum;
    logic [16:0]        w_sum_u;
    logic [16:0]        w_mag;
    logic [31:0]        w_dt;
    logic [48:0]        w_prod;
    logic [42:0]        w_q;
    logic signed [42:0] w_step;
    logic signed [44:0] w_u;
    logic [31:0]        w_used_new;
    logic [31:0]        w_diff;
    logic [46:0]        w_pct_prod;
    logic [31:0]        w_load_sat;

    assign w_uw        = ucode_rom(r_pc);
    assign o_in_ready  = (w_uw.op == UOP_FETCH);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_fire  = (w_uw.op == UOP_OUT) && (!r_out_valid || i_out_ready);
    assign w_cap_q16   = {r_cap, 16'd0};

    // next step
    always_comb begin
        n_pc = r_pc;
        case (w_uw.cond)
            UC_NEXT:     n_pc = r_pc + 4'd1;
            UC_GOTO:     n_pc = w_uw.target;
            UC_IN_WAIT: begin
                if (i_in_valid) begin
                    n_pc = i_kind ? w_uw.target : r_pc + 4'd1;
                end
            end
            UC_DIV_BUSY: n_pc = w_div_busy ? r_pc : r_pc + 4'd1;
            UC_OUT_WAIT: n_pc = (!r_out_valid || i_out_ready) ? w_uw.target : r_pc;
            default:     n_pc = PC_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    // trapezoid product: |I + Iprev| * dt
    always_comb begin
        w_sum   = 17'(r_cur) + 17'(r_last_cur);
        w_sum_u = w_sum;
        w_mag   = w_sum[16] ? (17'd0 - w_sum_u) : w_sum_u;
        w_dt    = r_time - r_last_time;
        w_prod  = w_mag * w_dt;
    end

    // signed step charge and clamped used capacity
    always_comb begin
        w_q    = w_div_quot[42:0];
        w_step = r_neg ? $signed(43'd0 - w_q) : $signed(w_q);
        if (r_chg) begin
            w_u = $signed({13'd0, r_used}) - 45'(w_step);
        end else begin
            w_u = $signed({13'd0, r_used}) + 45'(w_step);
        end
        if (w_u[44]) begin
            w_used_new = 32'd0;
        end else if (w_u[43:0] > {12'd0, w_cap_q16}) begin
            w_used_new = w_cap_q16;
        end else begin
            w_used_new = w_u[31:0];
        end
    end

    // percent numerator and load saturation
    assign w_diff     = w_cap_q16 - r_used;
    assign w_pct_prod = w_diff * PCT_Q8_FULL;
    assign w_load_sat = (r_load > w_cap_q16) ? w_cap_q16 : r_load;

    // divider operand selection
    always_comb begin
        w_div_ctl.start = (w_uw.op == UOP_DIV_STEP) || (w_uw.op == UOP_DIV_PCT);
        if (w_uw.op == UOP_DIV_STEP) begin
            w_div_ctl.iters = STEP_DIV_ITERS;
            w_div_rem       = {12'd0, r_acc[63:44]};
            w_div_qd        = {r_acc[43:0], 20'd0};
            w_div_divisor   = MS_PER_HOUR;
        end else begin
            w_div_ctl.iters = PCT_DIV_ITERS;
            w_div_rem       = r_acc[47:16];
            w_div_qd        = {r_acc[15:0], 48'd0};
            w_div_divisor   = w_cap_q16;
        end
    end

    ccfg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_div_ctl),
        .i_rem     (w_div_rem),
        .i_qd      (w_div_qd),
        .i_divisor (w_div_divisor),
        .o_busy    (w_div_busy),
        .o_quot    (w_div_quot)
    );

    // capacity register and gauge state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_used      <= 32'd0;
            r_last_cur  <= 16'sd0;
            r_last_time <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_uw.op == UOP_MUL) begin
                r_last_cur  <= r_cur;
                r_last_time <= r_time;
            end
            if (w_uw.op == UOP_APPLY) begin
                r_used <= w_used_new;
            end else if (w_uw.op == UOP_LOAD) begin
                r_used <= w_load_sat;
            end
        end
    end

    // input capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cur  <= i_current_ma;
            r_time <= i_time_ms;
            r_chg  <= i_charging;
            r_load <= i_load_value;
        end
        case (w_uw.op)
            UOP_MUL: begin
                r_neg <= w_sum[16];
                r_acc <= {w_prod, 15'd0};
            end
            UOP_APPLY: begin
                r_step <= w_step;
            end
            UOP_LOAD: begin
                r_step <= 43'sd0;
            end
            UOP_PCT_MUL: begin
                r_pct_zero <= (r_cap == 16'd0) || (r_used >= w_cap_q16);
                r_acc      <= {17'd0, w_pct_prod};
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_o_used <= r_used;
            r_o_pct  <= r_pct_zero ? 15'd0 : w_div_quot[14:0];
            r_o_step <= r_step;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_used_q16         = r_o_used;
    assign o_remaining_pct_q8 = r_o_pct;
    assign o_step_charge_q16  = r_o_step;

    // the divider is idle whenever a word can be accepted
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_busy)
        else $error("divider busy while accepting a word");

    // a load word branches straight to the preset step
    a_load_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_kind) |=> (r_pc == PC_LOAD))
        else $error("load word did not branch to preset step");

    // a result only appears from the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_uw.op == UOP_OUT))
        else $error("result valid raised outside output step");

    // percent never exceeds 100
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_pct <= PCT_Q8_FULL))
        else $error("remaining percent above full scale");

endmodule
